// ===== src/red_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_pkg: shared types and constants for the reservation departure search
// Opcodes, status codes, table indexes and default sizes.
// ----------------------------------------------------------------------------
`default_nettype none
package red_pkg;
  localparam int ENTRIES_PER_TABLE = 64;
  localparam int TIME_BITS         = 40;
  localparam int VEHICLE_BITS      = 16;
  localparam int NUM_TABLES        = 4;

  localparam int OP_W    = 2;
  localparam int TSEL_W  = 2;
  localparam int STAT_W  = 2;
  localparam int FVEH_W  = 16;
  localparam int FTIME_W = 40;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK          = 2'd0;
  localparam logic [STAT_W-1:0] ST_UNREACHABLE = 2'd1;
  localparam logic [STAT_W-1:0] ST_STALLED     = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL        = 2'd3;

  localparam logic [TSEL_W-1:0] TB_WAIT     = 2'd0;
  localparam logic [TSEL_W-1:0] TB_EDGE     = 2'd1;
  localparam logic [TSEL_W-1:0] TB_ARRIVAL  = 2'd2;
  localparam logic [TSEL_W-1:0] TB_CORRIDOR = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TSEL_W-1:0]  table_sel;
    logic [FVEH_W-1:0]  entry_vehicle;
    logic [FTIME_W-1:0] entry_start;
    logic [FTIME_W-1:0] entry_end;
    logic [FVEH_W-1:0]  query_vehicle;
    logic [FTIME_W-1:0] not_before;
    logic [FTIME_W-1:0] travel_time;
    logic               use_corridor;
    logic [FTIME_W-1:0] corridor_travel;
  } in_item_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FTIME_W-1:0] departure_time;
  } out_item_t;
endpackage
`default_nettype wire

// ===== src/red_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_in_if / red_out_if: valid-ready channels
// Input beats carry an operation, result beats a status and departure time.
// ----------------------------------------------------------------------------
`default_nettype none
interface red_in_if;
  logic valid;
  logic ready;
  red_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface red_out_if;
  logic valid;
  logic ready;
  red_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/red_mem.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// red_mem: reservation entry store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module red_mem #(
  parameter int DEPTH  = 256,
  parameter int WIDTH  = 96,
  parameter int ADDR_W = 8
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [WIDTH-1:0]  rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== src/reservation_earliest_departure.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reservation_earliest_departure: earliest conflict-free departure search
// Four reservation tables in one entry memory, scanned by a query sequencer.
// ----------------------------------------------------------------------------
// Clear, append and no-op: result beat valid the cycle after the input beat.
// Query: per round, the wait, edge, arrival and corridor tables are scanned in
//   turn through the single read port of the entry memory (a scan ends at its
//   first conflict; a skipped or empty table is passed over); rounds repeat
//   until conflict-free or no later blocking end is found, then the result.
// One item at a time. Reset empties all tables; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
module reservation_earliest_departure #(
  parameter int ENTRIES_PER_TABLE = red_pkg::ENTRIES_PER_TABLE,
  parameter int TIME_BITS         = red_pkg::TIME_BITS,
  parameter int VEHICLE_BITS      = red_pkg::VEHICLE_BITS
) (
  input wire logic clk,
  input wire logic rst_n,
  red_in_if.sink   in_ch,
  red_out_if.source out_ch
);
  localparam int IDX_W  = (ENTRIES_PER_TABLE > 1) ? $clog2(ENTRIES_PER_TABLE) : 1;
  localparam int FILL_W = $clog2(ENTRIES_PER_TABLE + 1);
  localparam int ADDR_W = IDX_W + 2;
  localparam int DEPTH  = red_pkg::NUM_TABLES * (1 << IDX_W);
  localparam int WIDTH  = VEHICLE_BITS + 2 * TIME_BITS;
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic [FILL_W-1:0] FULL_N = FILL_W'(ENTRIES_PER_TABLE);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_DECIDE = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [FILL_W-1:0] fill_r [4];
  logic [VEHICLE_BITS-1:0] veh_r;
  logic [TIME_BITS-1:0] nb_r, trav_r, ctrav_r, cand_r, arr_r, cend_r, maxb_r;
  logic corr_r, any_r;
  logic [1:0] tbl_r;
  logic [FILL_W-1:0] idx_r;
  logic rd_pend_r;
  logic [red_pkg::STAT_W-1:0] ostat_r;
  logic [TIME_BITS-1:0] odep_r;
  logic ovalid_r;

  logic wr_en;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [WIDTH-1:0] wr_data, rd_data;
  logic [VEHICLE_BITS-1:0] e_veh;
  logic [TIME_BITS-1:0] e_s, e_e;

  red_mem #(.DEPTH(DEPTH), .WIDTH(WIDTH), .ADDR_W(ADDR_W)) u_mem (
    .clk, .wr_en, .wr_addr, .wr_data, .rd_addr, .rd_data
  );

  assign {e_veh, e_s, e_e} = rd_data;

  function automatic logic [TIME_BITS-1:0] sat_add(logic [TIME_BITS-1:0] a,
                                                   logic [TIME_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_BITS] ? TMAX : s[TIME_BITS-1:0];
  endfunction

  logic accept;
  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;
  assign accept = in_ch.valid && in_ch.ready;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data.status = ostat_r;
  assign out_ch.data.departure_time = red_pkg::FTIME_W'(odep_r);

  logic [1:0] a_tsel;
  assign a_tsel = in_ch.data.table_sel;
  assign wr_en = accept && (in_ch.data.op == red_pkg::OP_APPEND) &&
                 (fill_r[a_tsel] < FULL_N);
  assign wr_addr = {a_tsel, fill_r[a_tsel][IDX_W-1:0]};
  assign wr_data = {VEHICLE_BITS'(in_ch.data.entry_vehicle),
                    TIME_BITS'(in_ch.data.entry_start), TIME_BITS'(in_ch.data.entry_end)};
  assign rd_addr = {tbl_r, idx_r[IDX_W-1:0]};

  // table check conditions for the current round
  logic tbl_on;
  always_comb begin
    case (tbl_r)
      red_pkg::TB_WAIT:     tbl_on = cand_r > nb_r;
      red_pkg::TB_CORRIDOR: tbl_on = corr_r;
      default:              tbl_on = 1'b1;
    endcase
  end

  logic hit;
  always_comb begin
    case (tbl_r)
      red_pkg::TB_WAIT:     hit = (nb_r < e_e) && (e_s < cand_r);
      red_pkg::TB_EDGE:     hit = (cand_r < e_e) && (e_s < arr_r);
      red_pkg::TB_ARRIVAL:  hit = (e_s <= arr_r) && (arr_r < e_e);
      default:              hit = (cand_r < e_e) && (e_s < cend_r);
    endcase
    hit = hit && (e_veh != veh_r);
  end

  logic issue, last_tbl;
  assign issue = (state_r == S_SCAN) && tbl_on && (idx_r < fill_r[tbl_r]);
  assign last_tbl = (tbl_r == red_pkg::TB_CORRIDOR);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (accept) state_nxt = (in_ch.data.op == red_pkg::OP_QUERY) ? S_START : S_IDLE;
      S_START: state_nxt = S_SCAN;
      S_SCAN: begin
        if ((rd_pend_r && hit) || (!issue && !rd_pend_r)) begin
          state_nxt = last_tbl ? S_DECIDE : S_SCAN;
        end
      end
      S_DECIDE: state_nxt = (any_r && maxb_r != TMAX && maxb_r > cand_r) ? S_START : S_OUT;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ovalid_r  <= 1'b0;
      rd_pend_r <= 1'b0;
      for (int i = 0; i < 4; i++) fill_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_ch.valid && out_ch.ready) ovalid_r <= 1'b0;
      rd_pend_r <= issue && !(rd_pend_r && hit);
      if (accept) begin
        case (in_ch.data.op)
          red_pkg::OP_CLEAR: begin
            for (int i = 0; i < 4; i++) fill_r[i] <= '0;
            ostat_r <= red_pkg::ST_OK; odep_r <= '0; ovalid_r <= 1'b1;
          end
          red_pkg::OP_APPEND: begin
            if (wr_en) begin
              fill_r[a_tsel] <= fill_r[a_tsel] + 1'b1;
              ostat_r <= red_pkg::ST_OK;
            end else begin
              ostat_r <= red_pkg::ST_FULL;
            end
            odep_r <= '0; ovalid_r <= 1'b1;
          end
          red_pkg::OP_QUERY: begin
            veh_r   <= VEHICLE_BITS'(in_ch.data.query_vehicle);
            nb_r    <= TIME_BITS'(in_ch.data.not_before);
            cand_r  <= TIME_BITS'(in_ch.data.not_before);
            trav_r  <= TIME_BITS'(in_ch.data.travel_time);
            ctrav_r <= TIME_BITS'(in_ch.data.corridor_travel);
            corr_r  <= in_ch.data.use_corridor;
          end
          default: begin
            ostat_r <= red_pkg::ST_OK; odep_r <= '0; ovalid_r <= 1'b1;
          end
        endcase
      end
      case (state_r)
        S_START: begin
          arr_r  <= sat_add(cand_r, trav_r);
          cend_r <= sat_add(cand_r, ctrav_r);
          any_r  <= 1'b0;
          maxb_r <= '0;
          tbl_r  <= red_pkg::TB_WAIT;
          idx_r  <= '0;
        end
        S_SCAN: begin
          if (rd_pend_r && hit) begin
            if (!any_r || e_e > maxb_r) maxb_r <= e_e;
            any_r <= 1'b1;
          end
          if ((rd_pend_r && hit) || (!issue && !rd_pend_r)) begin
            tbl_r <= tbl_r + 2'd1;
            idx_r <= '0;
          end else if (issue) begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_DECIDE: begin
          if (!any_r) begin
            ostat_r <= red_pkg::ST_OK; odep_r <= cand_r;
          end else if (maxb_r == TMAX) begin
            ostat_r <= red_pkg::ST_UNREACHABLE; odep_r <= '0;
          end else if (maxb_r <= cand_r) begin
            ostat_r <= red_pkg::ST_STALLED; odep_r <= '0;
          end else begin
            cand_r <= maxb_r;
          end
        end
        S_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r[0] <= FULL_N && fill_r[1] <= FULL_N && fill_r[2] <= FULL_N && fill_r[3] <= FULL_N)
    else $error("table fill beyond capacity");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready)
    else $error("input taken during query");
  a_cand_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_START && $past(state_r) == S_DECIDE) |-> cand_r > nb_r)
    else $error("candidate did not advance");
  a_ok_dep: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && ostat_r == red_pkg::ST_OK) |-> odep_r >= nb_r)
    else $error("departure before not_before");
endmodule
`default_nettype wire

// ===== tb/reservation_earliest_departure_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reservation_earliest_departure_tb: self-checking bench for the departure search
// Directed and random clear/append/query/no-op beats; random gaps, output stalls.
// A local table model predicts each result beat, and the bench compares the
// beats in order.
// ----------------------------------------------------------------------------
`default_nettype none
module reservation_earliest_departure_tb;

  localparam logic [red_pkg::OP_W-1:0] OP_NOP = 2'd3;
  localparam logic [39:0]     FOREVER_T = '1;
  localparam int              MAX_CYCLES = 4_000_000;
  localparam int              NT = red_pkg::NUM_TABLES;
  localparam int              NE = red_pkg::ENTRIES_PER_TABLE;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  red_in_if  in_ch ();
  red_out_if out_ch ();

  reservation_earliest_departure dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // local copy of the tables
  logic [15:0] tab_veh   [NT][NE];
  logic [39:0] tab_start [NT][NE];
  logic [39:0] tab_end   [NT][NE];
  int          tab_fill  [NT];

  red_pkg::in_item_t  pending_beats [$];
  red_pkg::out_item_t expected_results [$];
  int errors = 0;
  int n_items = 0;
  int cycles = 0;
  int st_count [4];

  function automatic logic [39:0] sat_sum(logic [39:0] a, logic [39:0] b);
    logic [40:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[40] ? FOREVER_T : s[39:0];
  endfunction

  function automatic bit find_blocker(int t, logic [15:0] veh, bit point,
                                      logic [39:0] lo, logic [39:0] hi,
                                      output logic [39:0] blk_end);
    blk_end = '0;
    for (int i = 0; i < tab_fill[t]; i++) begin
      if (tab_veh[t][i] != veh) begin
        if (point ? (tab_start[t][i] <= lo && lo < tab_end[t][i])
                  : (lo < tab_end[t][i] && tab_start[t][i] < hi)) begin
          blk_end = tab_end[t][i];
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic red_pkg::out_item_t apply_beat(red_pkg::in_item_t b);
    red_pkg::out_item_t r;
    logic [39:0] cand, maxb, e, arr;
    bit any;
    int t;
    r.status = red_pkg::ST_OK;
    r.departure_time = '0;
    if (b.op == red_pkg::OP_CLEAR) begin
      for (int k = 0; k < NT; k++) tab_fill[k] = 0;
    end else if (b.op == red_pkg::OP_APPEND) begin
      t = b.table_sel;
      if (tab_fill[t] >= NE) begin
        r.status = red_pkg::ST_FULL;
      end else begin
        tab_veh[t][tab_fill[t]]   = b.entry_vehicle;
        tab_start[t][tab_fill[t]] = b.entry_start;
        tab_end[t][tab_fill[t]]   = b.entry_end;
        tab_fill[t]++;
      end
    end else if (b.op == red_pkg::OP_QUERY) begin
      cand = b.not_before;
      forever begin
        any = 0;
        maxb = '0;
        if (cand > b.not_before &&
            find_blocker(red_pkg::TB_WAIT, b.query_vehicle, 0, b.not_before, cand, e)) begin
          any = 1;
          maxb = e;
        end
        arr = sat_sum(cand, b.travel_time);
        if (find_blocker(red_pkg::TB_EDGE, b.query_vehicle, 0, cand, arr, e)) begin
          if (!any || e > maxb) maxb = e;
          any = 1;
        end
        if (find_blocker(red_pkg::TB_ARRIVAL, b.query_vehicle, 1, arr, '0, e)) begin
          if (!any || e > maxb) maxb = e;
          any = 1;
        end
        if (b.use_corridor && find_blocker(red_pkg::TB_CORRIDOR, b.query_vehicle, 0, cand,
                                           sat_sum(cand, b.corridor_travel), e)) begin
          if (!any || e > maxb) maxb = e;
          any = 1;
        end
        if (!any) begin
          r.departure_time = cand;
          break;
        end
        if (maxb == FOREVER_T) begin
          r.status = red_pkg::ST_UNREACHABLE;
          break;
        end
        if (maxb <= cand) begin
          r.status = red_pkg::ST_STALLED;
          break;
        end
        cand = maxb;
      end
    end
    return r;
  endfunction

  // stimulus builders
  function automatic logic [39:0] pick_time();
    int s;
    s = $urandom_range(0, 99);
    if (s < 85) return 40'($urandom_range(0, 3000));
    if (s < 90) return FOREVER_T;
    if (s < 93) return '0;
    return {8'($urandom), 32'($urandom)};
  endfunction

  function automatic red_pkg::in_item_t noise_beat();
    red_pkg::in_item_t b;
    b.op = red_pkg::OP_W'($urandom);
    b.table_sel = red_pkg::TSEL_W'($urandom);
    b.entry_vehicle = 16'($urandom);
    b.entry_start = {8'($urandom), 32'($urandom)};
    b.entry_end = {8'($urandom), 32'($urandom)};
    b.query_vehicle = 16'($urandom);
    b.not_before = {8'($urandom), 32'($urandom)};
    b.travel_time = {8'($urandom), 32'($urandom)};
    b.use_corridor = 1'($urandom);
    b.corridor_travel = {8'($urandom), 32'($urandom)};
    return b;
  endfunction

  task automatic push_clear();
    red_pkg::in_item_t b;
    b = noise_beat();
    b.op = red_pkg::OP_CLEAR;
    pending_beats.push_back(b);
  endtask

  task automatic push_append(logic [1:0] t, logic [15:0] v, logic [39:0] s,
                             logic [39:0] e);
    red_pkg::in_item_t b;
    b = noise_beat();
    b.op = red_pkg::OP_APPEND;
    b.table_sel = t;
    b.entry_vehicle = v;
    b.entry_start = s;
    b.entry_end = e;
    pending_beats.push_back(b);
  endtask

  task automatic push_query(logic [15:0] v, logic [39:0] nb, logic [39:0] tr,
                            bit corr, logic [39:0] ctr);
    red_pkg::in_item_t b;
    b = noise_beat();
    b.op = red_pkg::OP_QUERY;
    b.query_vehicle = v;
    b.not_before = nb;
    b.travel_time = tr;
    b.use_corridor = corr;
    b.corridor_travel = ctr;
    pending_beats.push_back(b);
  endtask

  task automatic build_stimulus();
    logic [39:0] s;
    int k;
    // directed
    push_query(16'd1, 40'd0, 40'd0, 1'b1, 40'd0);
    push_query(16'hffff, FOREVER_T, FOREVER_T, 1'b1, FOREVER_T);
    push_append(red_pkg::TB_EDGE, 16'd2, 40'd10, FOREVER_T);
    push_query(16'd1, 40'd0, 40'd20, 1'b0, 40'd0);
    push_query(16'd2, 40'd0, 40'd20, 1'b0, 40'd0);
    push_clear();
    push_append(red_pkg::TB_EDGE, 16'd2, 40'd0, 40'd100);
    push_append(red_pkg::TB_WAIT, 16'd3, 40'd50, 40'd60);
    push_query(16'd1, 40'd0, 40'd5, 1'b0, 40'd0);
    push_clear();
    push_append(red_pkg::TB_ARRIVAL, 16'd4, 40'd0, 40'd30);
    push_append(red_pkg::TB_CORRIDOR, 16'd5, 40'd25, 40'd80);
    push_append(red_pkg::TB_EDGE, 16'd6, 40'd70, 40'd90);
    push_query(16'd1, 40'd5, 40'd10, 1'b1, 40'd30);
    push_query(16'd1, 40'd5, 40'd10, 1'b0, 40'd30);
    push_query(16'd1, 40'd200, FOREVER_T, 1'b1, FOREVER_T);
    pending_beats.push_back(noise_beat());
    pending_beats[$].op = OP_NOP;
    push_clear();
    for (int i = 0; i < NE + 2; i++)
      push_append(red_pkg::TB_CORRIDOR, 16'(i), 40'(i * 10), 40'(i * 10 + 5));
    push_query(16'd0, 40'd0, 40'd3, 1'b1, 40'd4);
    push_clear();
    // random
    while (pending_beats.size() < 745) begin
      k = $urandom_range(0, 99);
      if (k < 75) begin
        if ($urandom_range(0, 2) == 0) push_clear();
        repeat ($urandom_range(0, 8)) begin
          s = pick_time();
          push_append(red_pkg::TSEL_W'($urandom), 16'($urandom_range(0, 4)), s,
                      ($urandom_range(0, 9) == 0) ? FOREVER_T
                                                  : sat_sum(s, 40'($urandom_range(0, 400))));
        end
        repeat ($urandom_range(1, 4))
          push_query(16'($urandom_range(0, 4)), 40'($urandom_range(0, 2500)),
                     ($urandom_range(0, 19) == 0) ? pick_time()
                                                  : 40'($urandom_range(0, 300)),
                     1'($urandom), 40'($urandom_range(0, 300)));
      end else if (k < 78) begin
        push_clear();
        repeat (NE + $urandom_range(1, 3)) begin
          s = pick_time();
          push_append(red_pkg::TSEL_W'($urandom_range(0, 3)), 16'($urandom), s,
                      sat_sum(s, 40'd50));
        end
        push_query(16'($urandom), 40'($urandom_range(0, 2000)), 40'd20, 1'b1, 40'd20);
        push_clear();
      end else begin
        pending_beats.push_back(noise_beat());
        if (pending_beats[$].op == OP_NOP && $urandom_range(0, 3) != 0)
          pending_beats[$].op = red_pkg::OP_QUERY;
      end
    end
  endtask

  // driver
  int  in_gap = 0;
  bit  in_burst = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(apply_beat(in_ch.data));
        n_items++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_ch.valid <= 1'b0;
        end else if (pending_beats.size() > 0) begin
          in_ch.data <= pending_beats.pop_front();
          in_ch.valid <= 1'b1;
          if ($urandom_range(0, 29) == 0) in_burst = ~in_burst;
          in_gap <= in_burst ? 0 : $urandom_range(0, 9);
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int  out_wait = 0;
  bit  out_burst = 0;
  red_pkg::out_item_t exp_r;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation: status %0d", out_ch.data.status);
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          st_count[out_ch.data.status]++;
          if (out_ch.data.status !== exp_r.status) begin
            $error("status expected %0d actual %0d", exp_r.status, out_ch.data.status);
            errors++;
          end
          if (out_ch.data.departure_time !== exp_r.departure_time) begin
            $error("departure_time expected %0d actual %0d",
                   exp_r.departure_time, out_ch.data.departure_time);
            errors++;
          end
        end
        if ($urandom_range(0, 29) == 0) out_burst = ~out_burst;
        out_wait = out_burst ? 0 : $urandom_range(0, 9);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    for (int k = 0; k < NT; k++) tab_fill[k] = 0;
    for (int k = 0; k < 4; k++) st_count[k] = 0;
    build_stimulus();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_beats.size() == 0 && !in_ch.valid && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      errors++;
    end
    $display("%0d beats: ok %0d, unreachable %0d, stalled %0d, full %0d",
             n_items, st_count[red_pkg::ST_OK], st_count[red_pkg::ST_UNREACHABLE],
             st_count[red_pkg::ST_STALLED], st_count[red_pkg::ST_FULL]);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
